// ----- sv/cfc_pkg.sv -----
// shared types and constants for the collatz first-crossing block
package cfc_pkg;

    typedef enum logic [1:0] {
        ST_CROSSED  = 2'd0,
        ST_NO_CROSS = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // largest x for which 3x+1 still fits in 64 bits
    localparam logic [63:0] OVF_LIMIT = 64'h5555_5555_5555_5554;

    // log3(2) with 32 fraction bits, truncated
    localparam logic [31:0] LOG3_2_Q32 = 32'd2709822657;

    localparam logic [7:0] STEP_LIMIT_RESET = 8'd170;

endpackage

// ----- sv/collatz_first_crossing.sv -----
// collatz first-crossing engine: one accelerated map step per clock
//
// Each transaction on s_ carries a 64-bit start value n. The engine runs the
// accelerated Collatz map one step per clock (odd x -> (3x+1)/2, even x -> x/2),
// counting odd steps q, and stops at the first step k where q drops below
// ceil(k * log3(2)) taken modulo 128. That barrier comes from a running fixed-point
// accumulator, so no table is stored. An item also ends on overflow, or when it
// runs out of steps, that is when k exceeds step_limit saturated at MAX_STEPS.
// s_ready is high only while the engine is idle. The result sits in an output
// register, so the next start value can be taken while the previous result
// waits on m_ready. step_limit is to be written through cfg_we/cfg_wdata only
// while the engine is idle; the block itself does not enforce this.
module collatz_first_crossing #(
    parameter int MAX_STEPS = 170
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_start_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_crossing_step,
    output logic [7:0]  m_odd_steps,
    output logic [63:0] m_final_value,
    output logic [63:0] m_drop
);

    localparam int KW = $clog2(MAX_STEPS + 2);
    localparam int QW = $clog2(MAX_STEPS + 1);
    localparam int IW = (KW > 7) ? KW : 7;
    localparam int AW = IW + 32;
    localparam int CW = (QW > 7) ? QW : 7;
    localparam int LW = (KW > 8) ? KW : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } state_t;

    state_t            state_reg;
    logic [7:0]        step_limit_reg;
    logic [63:0]       n_reg;
    logic [63:0]       x_reg;
    logic [QW-1:0]     q_reg;
    logic [KW-1:0]     k_reg;
    logic [AW-1:0]     acc_reg;
    cfc_pkg::status_t  status_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [7:0]        m_crossing_step_reg;
    logic [7:0]        m_odd_steps_reg;
    logic [63:0]       m_final_value_reg;
    logic [63:0]       m_drop_reg;

    logic              odd;
    logic [63:0]       x_half;
    logic [63:0]       x_next;
    logic [QW-1:0]     q_next;
    logic [6:0]        barrier;
    logic              crossed;
    logic              overflow;
    logic [LW-1:0]     lim_eff;
    logic              out_of_steps;
    logic              out_free;
    logic              done_crossed;

    assign odd      = x_reg[0];
    assign x_half   = {1'b0, x_reg[63:1]};
    // odd x: (3x+1)/2 = x + (x>>1) + 1
    assign x_next   = odd ? (x_reg + x_half + 64'd1) : x_half;
    assign q_next   = q_reg + QW'(odd);
    assign overflow = odd && (x_reg > cfc_pkg::OVF_LIMIT);

    // acc_reg holds k * log3(2); barrier is its ceiling (never an integer for k >= 1)
    assign barrier  = acc_reg[38:32] + 7'd1;
    assign crossed  = CW'(q_next) < CW'(barrier);

    always_comb begin
        if (LW'(step_limit_reg) > LW'(MAX_STEPS)) begin
            lim_eff = LW'(MAX_STEPS);
        end else begin
            lim_eff = LW'(step_limit_reg);
        end
    end

    assign out_of_steps = LW'(k_reg) > lim_eff;
    assign out_free     = !m_valid_reg || m_ready;
    assign done_crossed = status_reg == cfc_pkg::ST_CROSSED;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_limit_reg <= cfc_pkg::STEP_LIMIT_RESET;
        end else if (cfg_we) begin
            step_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // load a finished result, else retire the one just taken
            if (state_reg == S_FLUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        n_reg     <= s_start_value;
                        x_reg     <= s_start_value;
                        q_reg     <= '0;
                        k_reg     <= KW'(1);
                        acc_reg   <= AW'(cfc_pkg::LOG3_2_Q32);
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (out_of_steps) begin
                        status_reg <= cfc_pkg::ST_NO_CROSS;
                        state_reg  <= S_FLUSH;
                    end else if (overflow) begin
                        status_reg <= cfc_pkg::ST_OVERFLOW;
                        state_reg  <= S_FLUSH;
                    end else begin
                        x_reg <= x_next;
                        q_reg <= q_next;
                        if (crossed) begin
                            status_reg <= cfc_pkg::ST_CROSSED;
                            state_reg  <= S_FLUSH;
                        end else begin
                            k_reg   <= k_reg + KW'(1);
                            acc_reg <= acc_reg + AW'(cfc_pkg::LOG3_2_Q32);
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        m_status_reg <= status_reg;
                        if (done_crossed) begin
                            m_crossing_step_reg <= 8'(k_reg);
                            m_odd_steps_reg     <= 8'(q_reg);
                            m_final_value_reg   <= x_reg;
                            m_drop_reg          <= n_reg - x_reg;
                        end else begin
                            m_crossing_step_reg <= '0;
                            m_odd_steps_reg     <= '0;
                            m_final_value_reg   <= '0;
                            m_drop_reg          <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = state_reg == S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_crossing_step = m_crossing_step_reg;
    assign m_odd_steps     = m_odd_steps_reg;
    assign m_final_value   = m_final_value_reg;
    assign m_drop          = m_drop_reg;

endmodule

// ----- sv/cfc_checker.sv -----
// port-level checks for the collatz first-crossing block, bound to the top level
module cfc_checker #(
    parameter int MAX_STEPS = 170
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_crossing_step,
    input logic [7:0]  m_odd_steps,
    input logic [63:0] m_final_value,
    input logic [63:0] m_drop
);

    logic is_crossed;
    assign is_crossed = m_status == cfc_pkg::ST_CROSSED;

    // a result waiting on m_ready keeps m_valid, m_status, m_final_value and m_drop steady
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_final_value)
            && $stable(m_drop))
        else $error("result changed while stalled");

    // an accepted start value drops s_ready in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting a transaction");

    // only a crossing reports nonzero fields
    a_zero_unless_crossed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !is_crossed |-> m_crossing_step == 8'd0 && m_odd_steps == 8'd0
            && m_final_value == 64'd0 && m_drop == 64'd0)
        else $error("nonzero fields without a crossing");

    // odd steps never outnumber steps taken
    a_odd_le_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && is_crossed && (MAX_STEPS < 256) |-> m_odd_steps <= m_crossing_step)
        else $error("odd step count above step index");

endmodule

bind collatz_first_crossing cfc_checker #(.MAX_STEPS(MAX_STEPS)) u_cfc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_crossing_step (m_crossing_step),
    .m_odd_steps     (m_odd_steps),
    .m_final_value   (m_final_value),
    .m_drop          (m_drop)
);
